### design/rrr_pkg.sv
// ----------------------------------------------------------------------------
// rrr_pkg
// Types and constants shared by the rounded rectangle fill rasteriser.
// ----------------------------------------------------------------------------
package rrr_pkg;

  localparam int COORD_BITS = 12;
  localparam int SIZE_W     = 11;
  localparam int RAD_W      = 10;
  localparam int COLOR_W    = 24;
  localparam int BYTE_W     = 8;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int ADDR_W     = 2 * CFG_W;
  localparam int CNT_W      = SIZE_W;
  localparam int PH_W       = 3;
  localparam int NUM_PH     = 1 << PH_W;
  // Internal screen and buffer coordinates: origin plus offset, then the
  // rotation against the stride, all fit with three bits of headroom.
  localparam int PIX_W      = COORD_BITS + 3;

  localparam logic [CFG_W-1:0] COLUMNS_RESET = 12'd480;
  localparam logic [CFG_W-1:0] ROWS_RESET    = 12'd800;

  typedef enum logic [1:0] {
    MODE_STEP,
    MODE_RECT,
    MODE_ROUND,
    MODE_BAR
  } mode_t;

  typedef enum logic [1:0] {
    KIND_IDLE,
    KIND_RECT,
    KIND_ROUND,
    KIND_BAR
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS,
    REG_ROWS
  } reg_idx_t;

  typedef struct packed {
    mode_t                   mode;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic [SIZE_W-1:0]       shape_width;
    logic [SIZE_W-1:0]       shape_height;
    logic [RAD_W-1:0]        corner_radius;
    logic [COLOR_W-1:0]      fill_color;
  } in_item_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0] blue_byte;
    logic [BYTE_W-1:0] green_byte;
    logic [BYTE_W-1:0] red_byte;
    logic              last_pixel;
  } out_item_t;

endpackage

### design/rotated_rounded_rect_raster_top.sv
// ----------------------------------------------------------------------------
// rotated_rounded_rect_raster_top
// Fill rasteriser for rectangles, rounded rectangles and left-rounded bars,
// producing rotated, clipped BGR byte writes for a frame buffer.
//
// A start request (mode 1 to 3) latches a shape and gives no result; every
// step request (mode 0) gives exactly one result for the next candidate pixel.
// One request is accepted per clock cycle while in_stall is low. A step's
// result is registered through shape walker and pixel origin, then bounds
// check with the stride multiply and the three squares for the circle test,
// then the address and the output register. The three stages advance
// together whenever the output register is empty or being taken, so in_stall
// only follows out_stall while a result is held. cfg_ready is always high.
// Users must write registers only while no request is in flight; unenforced.
// ----------------------------------------------------------------------------
module rotated_rounded_rect_raster_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  rrr_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rrr_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rrr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rrr_pkg::CFG_W-1:0]            cfg_data
);
  import rrr_pkg::*;

  // Phase numbers of each shape kind.
  localparam logic [PH_W-1:0] RECT_BODY    = 3'd0;
  localparam logic [PH_W-1:0] ROUND_CENTRE = 3'd0;
  localparam logic [PH_W-1:0] ROUND_TOP    = 3'd1;
  localparam logic [PH_W-1:0] ROUND_BOTTOM = 3'd2;
  localparam logic [PH_W-1:0] ROUND_TL     = 3'd3;
  localparam logic [PH_W-1:0] ROUND_TR     = 3'd4;
  localparam logic [PH_W-1:0] ROUND_BR     = 3'd5;
  localparam logic [PH_W-1:0] ROUND_BL     = 3'd6;
  localparam logic [PH_W-1:0] BAR_BODY     = 3'd0;
  localparam logic [PH_W-1:0] BAR_TL       = 3'd1;
  localparam logic [PH_W-1:0] BAR_BL       = 3'd2;
  localparam logic [PH_W-1:0] BAR_GAP      = 3'd3;

  // Configuration registers
  logic [CFG_W-1:0] cols_r, rows_r;

  // Shape state
  kind_t                   kind_r, kind_nxt;
  logic [PH_W-1:0]         ph_r, ph_nxt;
  logic [CNT_W-1:0]        inner_r, inner_nxt, outer_r, outer_nxt;
  logic signed [COORD_BITS-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [SIZE_W-1:0]       w_r, w_nxt, h_r, h_nxt;
  logic [RAD_W-1:0]        r_r, r_nxt;
  logic [COLOR_W-1:0]      color_r, color_nxt;

  // Pipeline control
  logic en, acc, is_step;

  // Phase selection
  logic [NUM_PH-1:0] ne, avail, lowest;
  logic [PH_W-1:0]   cur;
  logic              busy, more;

  // Current phase descriptor
  logic                    quad, neg_x, neg_y;
  logic signed [PIX_W-1:0] ox, oy;
  logic [CNT_W-1:0]        nx, ny;
  logic signed [PIX_W-1:0] xs, ys, ws, hs, rs, xr, yr, x_right, y_low_q, y_low_r;
  logic signed [PIX_W-1:0] dxs, dys, px, py;
  logic [CNT_W:0]          inner_inc, outer_inc;
  logic                    end_row, end_phase, last_cand;

  // Radius clamp for a start request
  logic [RAD_W-1:0] w_half, h_half, r_req, r_min1, r_clamp;

  // Stage 1
  logic                    s1_vld_r, s1_act_r, s1_last_r, s1_quad_r;
  logic signed [PIX_W-1:0] s1_px_r, s1_py_r;
  logic [RAD_W-1:0]        s1_dx_r, s1_dy_r, s1_rad_r;
  logic [COLOR_W-1:0]      s1_color_r;

  // Stage 2
  logic                    s2_vld_r, s2_act_r, s2_last_r, s2_quad_r, s2_inb_r;
  logic [ADDR_W-1:0]       s2_prod_r;
  logic [CFG_W-1:0]        s2_bx_r;
  logic [2*RAD_W-1:0]      s2_dx2_r, s2_dy2_r, s2_r2_r;
  logic [COLOR_W-1:0]      s2_color_r;
  logic signed [PIX_W-1:0] bx, cols_s, rows_s;
  logic                    inb;

  // Output stage
  logic                    out_valid_r;
  out_item_t               out_data_r, out_nxt;
  logic                    in_circle, wr;
  logic [ADDR_W-1:0]       lin;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign acc      = in_valid && en;
  assign is_step  = (in_data.mode == MODE_STEP);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLUMNS_RESET;
      rows_r <= ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_COLUMNS) begin
        cols_r <= cfg_data;
      end else if (cfg_index == REG_ROWS) begin
        rows_r <= cfg_data;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Phase occupancy and selection. An empty phase is skipped by looking for
  // the first occupied phase at or after ph_r.
  // --------------------------------------------------------------------------
  always_comb begin
    ne = '0;
    case (kind_r)
      KIND_RECT: begin
        ne[RECT_BODY] = (w_r != '0) && (h_r != '0);
      end
      KIND_ROUND: begin
        ne[ROUND_CENTRE] = (w_r != '0) && (h_r > {r_r, 1'b0});
        ne[ROUND_TOP]    = (w_r > {r_r, 1'b0}) && (r_r != '0);
        ne[ROUND_BOTTOM] = (w_r > {r_r, 1'b0}) && (r_r != '0);
        ne[ROUND_TL]     = 1'b1;
        ne[ROUND_TR]     = 1'b1;
        ne[ROUND_BR]     = 1'b1;
        ne[ROUND_BL]     = 1'b1;
      end
      KIND_BAR: begin
        ne[BAR_BODY] = (w_r > {1'b0, r_r}) && (h_r != '0);
        ne[BAR_TL]   = 1'b1;
        ne[BAR_BL]   = 1'b1;
        ne[BAR_GAP]  = (r_r != '0) && (h_r > {r_r, 1'b0});
      end
      default: ne = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_PH; i++) begin
      avail[i] = ne[i] && (PH_W'(i) >= ph_r);
    end
    cur = '0;
    for (int i = NUM_PH - 1; i >= 0; i--) begin
      if (avail[i]) begin
        cur = PH_W'(i);
      end
    end
  end

  assign busy   = |avail;
  assign lowest = avail & (~avail + NUM_PH'(1));
  assign more   = |(avail & ~lowest);

  // --------------------------------------------------------------------------
  // Descriptor of the selected phase
  // --------------------------------------------------------------------------
  assign xs      = PIX_W'(x_r);
  assign ys      = PIX_W'(y_r);
  assign ws      = signed'(PIX_W'(w_r));
  assign hs      = signed'(PIX_W'(h_r));
  assign rs      = signed'(PIX_W'(r_r));
  assign xr      = xs + rs;
  assign yr      = ys + rs;
  assign x_right = xs + ws - rs - PIX_W'(1);
  assign y_low_q = ys + hs - rs - PIX_W'(1);
  assign y_low_r = ys + hs - rs;

  always_comb begin
    quad  = 1'b0;
    neg_x = 1'b0;
    neg_y = 1'b0;
    ox    = xs;
    oy    = ys;
    nx    = w_r;
    ny    = h_r;
    case (kind_r)
      KIND_ROUND: begin
        case (cur)
          ROUND_CENTRE: begin
            oy = yr;
            ny = h_r - {r_r, 1'b0};
          end
          ROUND_TOP: begin
            ox = xr;
            nx = w_r - {r_r, 1'b0};
            ny = CNT_W'(r_r);
          end
          ROUND_BOTTOM: begin
            ox = xr;
            oy = y_low_r;
            nx = w_r - {r_r, 1'b0};
            ny = CNT_W'(r_r);
          end
          ROUND_TL: begin
            quad = 1'b1; neg_x = 1'b1; neg_y = 1'b1;
            ox = xr; oy = yr;
          end
          ROUND_TR: begin
            quad = 1'b1; neg_y = 1'b1;
            ox = x_right; oy = yr;
          end
          ROUND_BR: begin
            quad = 1'b1;
            ox = x_right; oy = y_low_q;
          end
          ROUND_BL: begin
            quad = 1'b1; neg_x = 1'b1;
            ox = xr; oy = y_low_q;
          end
          default: begin
            quad = 1'b0;
          end
        endcase
      end
      KIND_BAR: begin
        case (cur)
          BAR_BODY: begin
            ox = xr;
            nx = w_r - CNT_W'(r_r);
          end
          BAR_TL: begin
            quad = 1'b1; neg_x = 1'b1; neg_y = 1'b1;
            ox = xr; oy = yr;
          end
          BAR_BL: begin
            quad = 1'b1; neg_x = 1'b1;
            ox = xr; oy = y_low_q;
          end
          BAR_GAP: begin
            oy = yr;
            nx = CNT_W'(r_r);
            ny = h_r - {r_r, 1'b0};
          end
          default: begin
            quad = 1'b0;
          end
        endcase
      end
      default: begin
        quad = 1'b0;
      end
    endcase
    // Every corner quadrant spans the radius plus one in both directions.
    if (quad) begin
      nx = CNT_W'(r_r) + CNT_W'(1);
      ny = CNT_W'(r_r) + CNT_W'(1);
    end
  end

  assign dxs = signed'(PIX_W'(inner_r));
  assign dys = signed'(PIX_W'(outer_r));
  assign px  = neg_x ? (ox - dxs) : (ox + dxs);
  assign py  = neg_y ? (oy - dys) : (oy + dys);

  assign inner_inc = {1'b0, inner_r} + (CNT_W+1)'(1);
  assign outer_inc = {1'b0, outer_r} + (CNT_W+1)'(1);
  assign end_row   = (inner_inc >= {1'b0, nx});
  assign end_phase = end_row && (outer_inc >= {1'b0, ny});
  assign last_cand = end_phase && !more;

  // --------------------------------------------------------------------------
  // Radius clamp and walker update
  // --------------------------------------------------------------------------
  assign w_half  = in_data.shape_width[SIZE_W-1:1];
  assign h_half  = in_data.shape_height[SIZE_W-1:1];
  assign r_req   = (in_data.mode == MODE_ROUND) ? in_data.corner_radius : h_half;
  assign r_min1  = (r_req > w_half) ? w_half : r_req;
  assign r_clamp = (r_min1 > h_half) ? h_half : r_min1;

  always_comb begin
    kind_nxt  = kind_r;
    ph_nxt    = ph_r;
    inner_nxt = inner_r;
    outer_nxt = outer_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    r_nxt     = r_r;
    color_nxt = color_r;
    if (acc) begin
      if (!is_step) begin
        case (in_data.mode)
          MODE_RECT:  kind_nxt = KIND_RECT;
          MODE_ROUND: kind_nxt = KIND_ROUND;
          MODE_BAR:   kind_nxt = KIND_BAR;
          default:    kind_nxt = KIND_IDLE;
        endcase
        ph_nxt    = '0;
        inner_nxt = '0;
        outer_nxt = '0;
        x_nxt     = in_data.pos_x;
        y_nxt     = in_data.pos_y;
        w_nxt     = in_data.shape_width;
        h_nxt     = in_data.shape_height;
        r_nxt     = r_clamp;
        color_nxt = in_data.fill_color;
      end else if (busy) begin
        if (!end_row) begin
          inner_nxt = inner_inc[CNT_W-1:0];
        end else if (!end_phase) begin
          inner_nxt = '0;
          outer_nxt = outer_inc[CNT_W-1:0];
        end else begin
          inner_nxt = '0;
          outer_nxt = '0;
          ph_nxt    = cur + PH_W'(1);
          if (!more) begin
            kind_nxt = KIND_IDLE;
            ph_nxt   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_IDLE;
      ph_r    <= '0;
      inner_r <= '0;
      outer_r <= '0;
    end else begin
      kind_r  <= kind_nxt;
      ph_r    <= ph_nxt;
      inner_r <= inner_nxt;
      outer_r <= outer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    r_r     <= r_nxt;
    color_r <= color_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 1: candidate pixel in screen space
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= acc && is_step;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_act_r   <= busy;
      s1_last_r  <= busy ? last_cand : 1'b1;
      s1_quad_r  <= quad;
      s1_px_r    <= px;
      s1_py_r    <= py;
      s1_dx_r    <= inner_r[RAD_W-1:0];
      s1_dy_r    <= outer_r[RAD_W-1:0];
      s1_rad_r   <= r_r;
      s1_color_r <= color_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: rotation, clipping, stride product and circle squares
  // --------------------------------------------------------------------------
  assign cols_s = signed'(PIX_W'(cols_r));
  assign rows_s = signed'(PIX_W'(rows_r));
  assign bx     = cols_s - s1_py_r - PIX_W'(1);
  assign inb    = !bx[PIX_W-1] && (bx < cols_s) &&
                  !s1_px_r[PIX_W-1] && (s1_px_r < rows_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  // The buffer row is the screen column; it only matters once it is known
  // to lie below the row count, so its low bits are enough for the product.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_act_r   <= s1_act_r;
      s2_last_r  <= s1_last_r;
      s2_quad_r  <= s1_quad_r;
      s2_inb_r   <= inb;
      s2_prod_r  <= ADDR_W'(s1_px_r[CFG_W-1:0]) * ADDR_W'(cols_r);
      s2_bx_r    <= bx[CFG_W-1:0];
      s2_dx2_r   <= (2*RAD_W)'(s1_dx_r) * (2*RAD_W)'(s1_dx_r);
      s2_dy2_r   <= (2*RAD_W)'(s1_dy_r) * (2*RAD_W)'(s1_dy_r);
      s2_r2_r    <= (2*RAD_W)'(s1_rad_r) * (2*RAD_W)'(s1_rad_r);
      s2_color_r <= s1_color_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: write decision, byte address and output register
  // --------------------------------------------------------------------------
  assign in_circle = ((2*RAD_W+1)'(s2_dx2_r) + (2*RAD_W+1)'(s2_dy2_r)) <=
                     (2*RAD_W+1)'(s2_r2_r);
  assign wr  = s2_act_r && s2_inb_r && (!s2_quad_r || in_circle);
  assign lin = s2_prod_r + ADDR_W'(s2_bx_r);

  always_comb begin
    out_nxt             = '0;
    out_nxt.write_valid = wr;
    out_nxt.last_pixel  = s2_last_r;
    if (wr) begin
      out_nxt.byte_address = lin + {lin[ADDR_W-2:0], 1'b0};
      out_nxt.blue_byte    = s2_color_r[BYTE_W-1:0];
      out_nxt.green_byte   = s2_color_r[2*BYTE_W-1:BYTE_W];
      out_nxt.red_byte     = s2_color_r[3*BYTE_W-1:2*BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skip_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.write_valid) |->
      (out_data.byte_address == '0 && out_data.blue_byte == '0 &&
       out_data.green_byte == '0 && out_data.red_byte == '0))
    else $error("skipped candidate carries a non-zero address or colour");

  a_inner_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (inner_r < nx))
    else $error("column counter ran past the width of the current phase");

  a_outer_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (outer_r < ny))
    else $error("row counter ran past the height of the current phase");

endmodule
